FILE: hdl/assert_macros.svh
// assertion macros for the top level rtl file of the energy counter
// no dependencies, uses clk and arst_n of the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: hdl/gtec_pkg.sv
// package of the gated trapezoid energy counter: widths, codes, states, helpers
// no dependencies
`timescale 1ns / 1ps

package gtec_pkg;

	localparam int VOLT_W   = 16;
	localparam int CUR_W    = 18;
	localparam int TIME_W   = 32;
	localparam int CFG_W    = 20;
	localparam int ACC_W    = 63;
	localparam int NET_W    = 64;
	localparam int CYC_W    = 32;
	localparam int PKC_W    = 17;
	localparam int PKD_W    = 18;
	localparam int MCAND_W  = 39;
	localparam int MPLIER_W = 20;
	localparam int PROD_W   = MCAND_W + MPLIER_W;
	localparam int DQ_W     = 39;
	localparam int DE_W     = 56;
	localparam int DIV_W    = 43;
	localparam int CNT_W    = 5;

	localparam logic [ACC_W-1:0]   ACC_MAX              = {ACC_W{1'b1}};
	localparam logic [CFG_W-1:0]   DEFAULT_CAPACITY_MAH = 20'd100000;
	localparam logic [MCAND_W-1:0] MS_PER_HOUR_X2       = 39'd7200000;
	localparam logic [CFG_W-1:0]   MAX_GAP_RESET        = 20'd5000;

	typedef enum logic {
		CFG_CAPACITY = 1'b0,
		CFG_MAX_GAP  = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_Q,
		ST_MUL_E,
		ST_WAIT_D,
		ST_DIV,
		ST_DONE
	} state_t;

	function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] acc,
			input logic [DE_W-1:0] inc);
		logic [ACC_W:0] sum;
		sum = {1'b0, acc} + {{(ACC_W + 1 - DE_W){1'b0}}, inc};
		return (sum >= {1'b0, ACC_MAX}) ? ACC_MAX : sum[ACC_W-1:0];
	endfunction

endpackage

FILE: hdl/gtec_if.sv
// stream interfaces for sample words and result words
// depends on gtec_pkg
`timescale 1ns / 1ps

interface gtec_in_if;
	logic                              valid;
	logic                              ready;
	logic                              cmd;
	logic [gtec_pkg::VOLT_W-1:0]       voltage_mv;
	logic signed [gtec_pkg::CUR_W-1:0] current_ma;
	logic                              voltage_valid;
	logic                              current_valid;
	logic [gtec_pkg::TIME_W-1:0]       time_ms;

	modport source (output valid, cmd, voltage_mv, current_ma, voltage_valid,
		current_valid, time_ms, input ready);
	modport sink (input valid, cmd, voltage_mv, current_ma, voltage_valid,
		current_valid, time_ms, output ready);
endinterface

interface gtec_out_if;
	logic                              valid;
	logic                              ready;
	logic                              integrated;
	logic [gtec_pkg::ACC_W-1:0]        charge_sum;
	logic [gtec_pkg::ACC_W-1:0]        discharge_sum;
	logic [gtec_pkg::ACC_W-1:0]        charge_energy;
	logic [gtec_pkg::ACC_W-1:0]        discharge_energy;
	logic signed [gtec_pkg::NET_W-1:0] net_charge;
	logic signed [gtec_pkg::NET_W-1:0] net_energy;
	logic [gtec_pkg::CYC_W-1:0]        full_cycles_q16;
	logic [gtec_pkg::PKC_W-1:0]        peak_charge_ma;
	logic [gtec_pkg::PKD_W-1:0]        peak_discharge_ma;
	logic [gtec_pkg::TIME_W-1:0]       last_gap_ms;

	modport source (output valid, integrated, charge_sum, discharge_sum, charge_energy,
		discharge_energy, net_charge, net_energy, full_cycles_q16, peak_charge_ma,
		peak_discharge_ma, last_gap_ms, input ready);
	modport sink (input valid, integrated, charge_sum, discharge_sum, charge_energy,
		discharge_energy, net_charge, net_energy, full_cycles_q16, peak_charge_ma,
		peak_discharge_ma, last_gap_ms, output ready);
endinterface

FILE: hdl/gtec_mul.sv
// bit-serial shift-add multiplier, one multiplier bit per cycle
// depends on gtec_pkg
`timescale 1ns / 1ps

module gtec_mul (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [gtec_pkg::MCAND_W-1:0]     a,
	input  logic [gtec_pkg::MPLIER_W-1:0]    b,
	output logic [gtec_pkg::PROD_W-1:0]      p,
	output logic                             busy
);
	import gtec_pkg::*;

	logic [MCAND_W-1:0]  a_q;
	logic [MCAND_W-1:0]  hi_q;
	logic [MPLIER_W-1:0] lo_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                busy_q;
	logic [MCAND_W:0]    sum;

	assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(MPLIER_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (busy_q) begin
			hi_q <= sum[MCAND_W:1];
			lo_q <= {sum[0], lo_q[MPLIER_W-1:1]};
		end
	end

	assign p    = {hi_q, lo_q};
	assign busy = busy_q;
endmodule

FILE: hdl/gtec_div.sv
// restoring divider for the q16 cycle count, one quotient bit per cycle
// depends on gtec_pkg; saturates when the quotient needs more than 32 bits
`timescale 1ns / 1ps

module gtec_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [gtec_pkg::ACC_W-1:0]    n,
	input  logic [gtec_pkg::DIV_W-1:0]    d,
	output logic [gtec_pkg::CYC_W-1:0]    q,
	output logic                          busy
);
	import gtec_pkg::*;

	logic [DIV_W-1:0] d_q;
	logic [DIV_W:0]   rem_q;
	logic [CYC_W-1:0] nsh_q;
	logic [CYC_W-1:0] quo_q;
	logic             sat_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DIV_W:0]   trial;
	logic             fits;

	assign trial = {rem_q[DIV_W-1:0], nsh_q[CYC_W-1]};
	assign fits  = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(CYC_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			d_q   <= d;
			// n >= d * 2^16 means the q16 result overflows 32 bits
			sat_q <= n >= {{(ACC_W - DIV_W - 16){1'b0}}, d, 16'b0};
			rem_q <= n[DIV_W+16:16];
			nsh_q <= {n[15:0], 16'b0};
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? (trial - {1'b0, d_q}) : trial;
			nsh_q <= {nsh_q[CYC_W-2:0], 1'b0};
			quo_q <= {quo_q[CYC_W-2:0], fits};
		end
	end

	assign q    = sat_q ? '1 : quo_q;
	assign busy = busy_q;
endmodule

FILE: hdl/gated_trapezoid_energy_counter_unit.sv
// top level of the gated trapezoid energy counter
// depends on gtec_pkg, gtec_if, gtec_mul, gtec_div and assert_macros.svh
`timescale 1ns / 1ps
//
// samples (sink) takes one word per item: a measurement or a clear command.
// results (source) gives exactly one result word per accepted word.
// cfg_we/cfg_index/cfg_data write capacity_mah (0) and max_gap_ms (1); write
// only while no word is in flight.
// one word is worked at a time. an integrated sample passes two 20-step serial
// multiplies (charge, then energy) and a 32-step serial divide for the q16 cycle
// count. other words pass only the capacity multiply and the divide.
// samples.ready is high only while the sequencer is idle; a finished result
// sits in the output register, so the next word is taken while it waits.
// if the receiver stalls with a result still held, the next result waits in
// its last step and no further word is taken.
// reset zeroes all counters, peaks, stored sample and gap, sets capacity to 0
// (built-in default) and max gap to 5000 ms; results.valid is low.
//
module gated_trapezoid_energy_counter_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	gtec_in_if.sink                     samples,
	gtec_out_if.source                  results,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [gtec_pkg::CFG_W-1:0]  cfg_data
);
	import gtec_pkg::*;

	`include "assert_macros.svh"

	state_t state_q, state_nx;

	logic [CFG_W-1:0]        cap_q, max_gap_q;
	logic [TIME_W-1:0]       prev_time_q;
	logic [VOLT_W-1:0]       prev_voltage_q;
	logic signed [CUR_W-1:0] prev_current_q;
	logic [ACC_W-1:0]        charge_q, discharge_q, charge_e_q, discharge_e_q;
	logic [PKC_W-1:0]        peak_c_q;
	logic [PKD_W-1:0]        peak_d_q;
	logic [TIME_W-1:0]       gap_q;
	logic                    integ_q;
	logic                    neg_q;
	logic [VOLT_W:0]         vsum_q;
	logic                    out_valid_q;

	logic                 accept, done_go;
	logic [CUR_W:0]       isum, mag;
	logic [VOLT_W:0]      vsum;
	logic [TIME_W-1:0]    gap;
	logic                 sample_ok, do_int;
	logic [CUR_W-1:0]     cur_neg;
	logic [CFG_W-1:0]     cap_eff;

	logic                 e_start, d_start, div_start;
	logic [MCAND_W-1:0]   e_a;
	logic [MPLIER_W-1:0]  e_b;
	logic [PROD_W-1:0]    e_p, d_p;
	logic                 e_busy, d_busy, div_busy;
	logic [CYC_W-1:0]     div_q;

	assign accept  = samples.valid && samples.ready;
	assign done_go = (state_q == ST_DONE) && (!out_valid_q || results.ready);

	assign isum = {samples.current_ma[CUR_W-1], samples.current_ma}
		+ {prev_current_q[CUR_W-1], prev_current_q};
	assign mag  = isum[CUR_W] ? (~isum + 1'b1) : isum;
	assign vsum = {1'b0, samples.voltage_mv} + {1'b0, prev_voltage_q};
	assign gap  = samples.time_ms - prev_time_q;
	assign sample_ok = !samples.cmd && samples.voltage_valid && samples.current_valid
		&& (prev_time_q != '0);
	assign do_int  = sample_ok && (gap != '0)
		&& (gap <= {{(TIME_W - CFG_W){1'b0}}, max_gap_q});
	assign cur_neg = ~samples.current_ma + 1'b1;
	assign cap_eff = (cap_q == '0) ? DEFAULT_CAPACITY_MAH : cap_q;

	// first pass: gap * |isum|, second pass: that product * vsum
	assign e_a = (state_q == ST_IDLE) ? {{(MCAND_W - CFG_W){1'b0}}, gap[CFG_W-1:0]}
		: e_p[DQ_W-1:0];
	assign e_b = (state_q == ST_IDLE) ? {{(MPLIER_W - CUR_W - 1){1'b0}}, mag}
		: {{(MPLIER_W - VOLT_W - 1){1'b0}}, vsum_q};

	gtec_mul u_mul_e (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (e_start),
		.a      (e_a),
		.b      (e_b),
		.p      (e_p),
		.busy   (e_busy)
	);

	gtec_mul u_mul_d (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (d_start),
		.a      (MS_PER_HOUR_X2),
		.b      (cap_eff),
		.p      (d_p),
		.busy   (d_busy)
	);

	gtec_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.n      (discharge_q),
		.d      (d_p[DIV_W-1:0]),
		.q      (div_q),
		.busy   (div_busy)
	);

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE:   if (accept) state_nx = do_int ? ST_MUL_Q : ST_WAIT_D;
			ST_MUL_Q:  if (!e_busy) state_nx = ST_MUL_E;
			ST_MUL_E:  if (!e_busy) state_nx = ST_WAIT_D;
			ST_WAIT_D: if (!d_busy) state_nx = ST_DIV;
			ST_DIV:    if (!div_busy) state_nx = ST_DONE;
			ST_DONE:   if (done_go) state_nx = ST_IDLE;
			default:   state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		samples.ready = (state_q == ST_IDLE);
		d_start       = (state_q == ST_IDLE) && accept;
		e_start       = ((state_q == ST_IDLE) && accept && do_int)
			|| ((state_q == ST_MUL_Q) && !e_busy);
		div_start     = (state_q == ST_WAIT_D) && !d_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (done_go) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q          <= '0;
			max_gap_q      <= MAX_GAP_RESET;
			prev_time_q    <= '0;
			prev_voltage_q <= '0;
			prev_current_q <= '0;
			charge_q       <= '0;
			discharge_q    <= '0;
			charge_e_q     <= '0;
			discharge_e_q  <= '0;
			peak_c_q       <= '0;
			peak_d_q       <= '0;
			gap_q          <= '0;
			integ_q        <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_CAPACITY: cap_q     <= cfg_data;
					CFG_MAX_GAP:  max_gap_q <= cfg_data;
					default:      ;
				endcase
			end
			if (accept) begin
				integ_q <= do_int;
				if (samples.cmd) begin
					charge_q      <= '0;
					discharge_q   <= '0;
					charge_e_q    <= '0;
					discharge_e_q <= '0;
					peak_c_q      <= '0;
					peak_d_q      <= '0;
				end else begin
					prev_time_q    <= samples.time_ms;
					prev_voltage_q <= samples.voltage_mv;
					prev_current_q <= samples.current_ma;
					if (sample_ok) begin
						gap_q <= gap;
					end
					if (do_int) begin
						if (!samples.current_ma[CUR_W-1] && samples.current_ma != '0
								&& samples.current_ma[PKC_W-1:0] > peak_c_q) begin
							peak_c_q <= samples.current_ma[PKC_W-1:0];
						end
						if (samples.current_ma[CUR_W-1] && cur_neg > peak_d_q) begin
							peak_d_q <= cur_neg;
						end
					end
				end
			end
			if ((state_q == ST_MUL_Q) && !e_busy) begin
				if (neg_q) begin
					discharge_q <= sat_add(discharge_q,
						{{(DE_W - DQ_W){1'b0}}, e_p[DQ_W-1:0]});
				end else begin
					charge_q <= sat_add(charge_q, {{(DE_W - DQ_W){1'b0}}, e_p[DQ_W-1:0]});
				end
			end
			if ((state_q == ST_MUL_E) && !e_busy) begin
				if (neg_q) begin
					discharge_e_q <= sat_add(discharge_e_q, e_p[DE_W-1:0]);
				end else begin
					charge_e_q <= sat_add(charge_e_q, e_p[DE_W-1:0]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q  <= isum[CUR_W];
			vsum_q <= vsum;
		end
	end

	always_ff @(posedge clk) begin
		if (done_go) begin
			results.integrated        <= integ_q;
			results.charge_sum        <= charge_q;
			results.discharge_sum     <= discharge_q;
			results.charge_energy     <= charge_e_q;
			results.discharge_energy  <= discharge_e_q;
			results.net_charge        <= {1'b0, charge_q} - {1'b0, discharge_q};
			results.net_energy        <= {1'b0, charge_e_q} - {1'b0, discharge_e_q};
			results.full_cycles_q16   <= div_q;
			results.peak_charge_ma    <= peak_c_q;
			results.peak_discharge_ma <= peak_d_q;
			results.last_gap_ms       <= gap_q;
		end
	end

	assign results.valid = out_valid_q;

	`ASSERT_NEXT(a_one_word_at_a_time, accept, !samples.ready)
	`ASSERT_IMPL(a_div_after_capacity, div_start, !d_busy && !e_busy)
	`ASSERT_NEXT(a_stall_holds_result,
		(state_q == ST_DONE) && out_valid_q && !results.ready, state_q == ST_DONE)
endmodule
